@@ sv/fpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fpsc_pkg: shared types and constants for the frustum plane sphere cull block
// Holds command codes, plane selection tables and fixed-point defaults.
// ----------------------------------------------------------------------------
package fpsc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_PLANES    = 6;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_COMPUTE = 2'd1,
      CMD_TEST    = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   // Column combined with column 3 for each plane
   function automatic logic [1:0] plane_col(input logic [2:0] p);
      logic [1:0] c;
      unique case (p)
         3'd0, 3'd1: c = 2'd2;
         3'd2, 3'd3: c = 2'd0;
         default:    c = 2'd1;
      endcase
      return c;
   endfunction

   // 1 when the plane adds the column, 0 when it subtracts
   function automatic logic plane_add(input logic [2:0] p);
      logic a;
      unique case (p)
         3'd0, 3'd3, 3'd4: a = 1'b1;
         default:          a = 1'b0;
      endcase
      return a;
   endfunction

endpackage

@@ sv/fpsc_ram.sv @@
// ----------------------------------------------------------------------------
// fpsc_ram: generic simple dual-port RAM (separate write and read ports)
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module fpsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/frustum_plane_sphere_cull.sv @@
// ----------------------------------------------------------------------------
// frustum_plane_sphere_cull: frustum plane extraction and sphere culling
// Loads a view-projection matrix, derives six unit-normal planes and tests
// bounding spheres against them in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when req_start is high and busy is low. Every
//   command answers one beat on rsp_valid with rsp_visible, held for one
//   cycle only; the receiver cannot stall, so nothing backs up. The next
//   command is taken in the cycle after the response at the earliest.
//   Load (cmd 0): the element is written, then the response. Cmd 3, or a
//   test with clipping off or before the first compute: the response only.
//   Test (cmd 2): per plane one read, four multiply-accumulates on the
//   shared 33x33 multiplier and a compare; the planes run in order and the
//   test stops at the first plane that culls.
//   Compute (cmd 1): per plane the matrix reads, a range check, the squares,
//   33 square-root steps, the bit-serial divider and write for each of the
//   four coefficients (no divide for a zero normal) and a step to advance.
//   Reset idles the sequencer, sets the clip enable to 1 and marks the plane
//   store empty (tests answer visible until the first compute). The matrix
//   is undefined until written. csr_ready is always high.
// ----------------------------------------------------------------------------
module frustum_plane_sphere_cull #(
   parameter int FRAC_BITS = fpsc_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_elem_index,
   input  logic signed [31:0] req_elem_value,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic [30:0] req_sphere_radius,
   output logic        rsp_valid,
   output logic        rsp_visible,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_clip_enable
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_RESP  = 13'b0000000000010,
      ST_TRD   = 13'b0000000000100,  // issue coefficient reads
      ST_TMUL  = 13'b0000000001000,  // multiply-accumulate per coefficient
      ST_TCMP  = 13'b0000000010000,
      ST_CRD   = 13'b0000000100000,  // read matrix pairs
      ST_CSUM  = 13'b0000001000000,
      ST_CSQ   = 13'b0000010000000,  // squares through the multiplier
      ST_CSQRT = 13'b0000100000000,
      ST_CDIV  = 13'b0001000000000,
      ST_CWR   = 13'b0010000000000,
      ST_CNEXT = 13'b0100000000000,
      ST_LOAD  = 13'b1000000000000
   } state_type;

   localparam int DIVW = 33 + FRAC_BITS;

   state_type state_ff, state_in;
   logic       clip_ff;
   logic       planes_ok_ff;
   logic       vis_ff, vis_in;
   logic [2:0] plane_ff, plane_in;
   logic [2:0] step_ff, step_in;   // row / coefficient index, one extra bit
   logic [6:0] cnt_ff, cnt_in;

   // Latched request
   logic [3:0]         eidx_ff;
   logic signed [31:0] eval_ff, cx_ff, cy_ff, cz_ff;
   logic [30:0]        rad_ff;

   // Test accumulator: products summed exactly
   logic signed [67:0] acc_ff, acc_in;

   // Plane build storage
   logic signed [32:0] raw_ff [4];
   logic signed [32:0] raw_in [4];
   logic signed [31:0] colw_ff, colw_in;  // latched M[r][3]
   logic [65:0]        ssq_ff, ssq_in;
   logic [65:0]        sqn_ff, sqn_in;
   logic [65:0]        sqr_ff, sqr_in;    // square root result
   logic [DIVW-1:0]    dnum_ff, dnum_in;
   logic [DIVW-1:0]    dquo_ff, dquo_in;
   logic [33:0]        drem_ff, drem_in;
   logic signed [31:0] coef_ff, coef_in;

   // Shared multiplier, registered output
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p_ff;

   // Memories
   logic        mx_we, pl_we;
   logic [3:0]  mx_wa, mx_ra;
   logic [4:0]  pl_wa, pl_ra;
   logic [31:0] mx_wd, mx_rd, pl_wd, pl_rd;

   fpsc_ram #(.WIDTH(32), .DEPTH(16)) u_mx (
      .clock(clock), .wr_en(mx_we), .wr_addr(mx_wa), .wr_data(mx_wd),
      .rd_addr(mx_ra), .rd_data(mx_rd));

   fpsc_ram #(.WIDTH(32), .DEPTH(24)) u_pl (
      .clock(clock), .wr_en(pl_we), .wr_addr(pl_wa), .wr_data(pl_wd),
      .rd_addr(pl_ra), .rd_data(pl_rd));

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_visible = vis_ff;

   // Register the product of the shared multiplier
   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   logic [1:0]  sel_col;
   logic        sel_add;
   logic signed [31:0] test_op;
   logic [65:0] sq_trial;
   logic [34:0] d_trial;
   logic [33:0] d_shift;
   logic signed [32:0] mag_big;
   logic [1:0]  rsel;
   logic [32:0] rmag;
   logic signed [33:0] sdiff;
   logic        big;

   always_comb begin
      sel_col = fpsc_pkg::plane_col(plane_ff);
      sel_add = fpsc_pkg::plane_add(plane_ff);
      rsel    = step_ff[1:0];
      rmag    = raw_ff[rsel][32] ? 33'(-raw_ff[rsel]) : 33'(raw_ff[rsel]);
      big     = 1'b0;
      for (int r = 0; r < 3; r++) begin
         mag_big = raw_ff[r][32] ? -raw_ff[r] : raw_ff[r];
         if (raw_ff[r] == 33'sh1_0000_0000 || mag_big[32:31] != 2'b00) begin
            big = 1'b1;
         end
      end
      unique case (rsel)
         2'd0:    test_op = cx_ff;
         2'd1:    test_op = cy_ff;
         2'd2:    test_op = cz_ff;
         default: test_op = 32'sd1 <<< FRAC_BITS;
      endcase
      sq_trial = sqr_ff + (66'd1 << (2 * (32 - cnt_ff[5:0])));
      d_shift  = {drem_ff[32:0], dnum_ff[DIVW-1]};
      d_trial  = {1'b0, d_shift} - {1'b0, sqr_ff[33:0]};
      sdiff    = sel_add ? 34'(colw_ff) + 34'(signed'(mx_rd))
                         : 34'(colw_ff) - 34'(signed'(mx_rd));
   end

   always_comb begin
      state_in = state_ff;
      vis_in   = vis_ff;
      plane_in = plane_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      raw_in   = raw_ff;
      colw_in  = colw_ff;
      ssq_in   = ssq_ff;
      sqn_in   = sqn_ff;
      sqr_in   = sqr_ff;
      dnum_in  = dnum_ff;
      dquo_in  = dquo_ff;
      drem_in  = drem_ff;
      coef_in  = coef_ff;
      mul_a    = 33'(rmag);
      mul_b    = 33'(rmag);
      mx_we    = 1'b0;
      mx_wa    = eidx_ff;
      mx_wd    = eval_ff;
      mx_ra    = 4'd0;
      pl_we    = 1'b0;
      pl_wa    = {plane_ff, 2'b00} + 5'(step_ff[1:0]);
      pl_wd    = coef_ff;
      pl_ra    = {plane_ff, 2'b00} + 5'(step_ff[1:0]);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               vis_in   = 1'b1;
               plane_in = '0;
               step_in  = '0;
               cnt_in   = '0;
               unique case (fpsc_pkg::cmd_type'(req_cmd))
                  fpsc_pkg::CMD_LOAD:    state_in = ST_LOAD;
                  fpsc_pkg::CMD_COMPUTE: state_in = ST_CRD;
                  fpsc_pkg::CMD_TEST:
                     state_in = (clip_ff && planes_ok_ff) ? ST_TRD : ST_RESP;
                  default:               state_in = ST_RESP;
               endcase
            end
         end
         ST_LOAD: begin
            mx_we    = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: state_in = ST_IDLE;

         // Sphere test: start with radius scaled to the product format
         ST_TRD: begin
            acc_in   = 68'(rad_ff) <<< FRAC_BITS;
            state_in = ST_TMUL;
            cnt_in   = '0;
         end
         ST_TMUL: begin
            // cnt 0: read issued; 1: multiply; 2: accumulate and advance
            mul_a = 33'(signed'(pl_rd));
            mul_b = 33'(test_op);
            if (cnt_ff == 7'd2) begin
               acc_in = acc_ff + 68'(mul_p_ff);
               cnt_in = '0;
               if (step_ff == 3'd3) begin
                  state_in = ST_TCMP;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_TCMP: begin
            step_in = '0;
            if (acc_ff < 0) begin
               vis_in   = 1'b0;
               state_in = ST_RESP;
            end else if (plane_ff == 3'(fpsc_pkg::NUM_PLANES - 1)) begin
               state_in = ST_RESP;
            end else begin
               plane_in = plane_ff + 3'd1;
               state_in = ST_TRD;
            end
         end

         // Plane build: read M[r][3] then M[r][c] for each row
         ST_CRD: begin
            mx_ra = cnt_ff[0] ? {step_ff[1:0], sel_col} : {step_ff[1:0], 2'd3};
            if (cnt_ff[1:0] == 2'd1) begin
               colw_in = signed'(mx_rd);
            end
            if (cnt_ff[1:0] == 2'd2) begin
               raw_in[rsel] = 33'(sdiff);
               cnt_in = '0;
               if (step_ff == 3'd3) begin
                  step_in  = '0;
                  state_in = ST_CSUM;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_CSUM: begin
            // Halve all four (floor) when a normal component is too large
            if (big) begin
               for (int r = 0; r < 4; r++) begin
                  raw_in[r] = raw_ff[r] >>> 1;
               end
            end
            ssq_in   = '0;
            cnt_in   = '0;
            step_in  = '0;
            state_in = ST_CSQ;
         end
         ST_CSQ: begin
            if (cnt_ff[0]) begin
               ssq_in = ssq_ff + 66'(mul_p_ff);
               cnt_in = '0;
               if (step_ff == 3'd2) begin
                  sqn_in   = ssq_ff + 66'(mul_p_ff);
                  sqr_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_CSQRT;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end else begin
               cnt_in = 7'd1;
            end
         end
         ST_CSQRT: begin
            // One result bit per cycle, highest of 33 first
            if (sqn_ff >= sq_trial) begin
               sqn_in = sqn_ff - sq_trial;
               sqr_in = (sqr_ff >> 1) + (66'd1 << (2 * (32 - cnt_ff[5:0])));
            end else begin
               sqr_in = sqr_ff >> 1;
            end
            if (cnt_ff == 7'd32) begin
               step_in  = '0;
               cnt_in   = '0;
               state_in = ST_CDIV;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_CDIV: begin
            if (cnt_ff == 7'd0) begin
               dnum_in = DIVW'(rmag) << FRAC_BITS;
               dquo_in = '0;
               drem_in = '0;
               cnt_in  = 7'd1;
               if (sqr_ff == '0) begin
                  coef_in  = '0;
                  state_in = ST_CWR;
               end
            end else begin
               dnum_in = dnum_ff << 1;
               if (!d_trial[34]) begin
                  drem_in = d_trial[33:0];
                  dquo_in = {dquo_ff[DIVW-2:0], 1'b1};
               end else begin
                  drem_in = d_shift;
                  dquo_in = {dquo_ff[DIVW-2:0], 1'b0};
               end
               if (cnt_ff == 7'(DIVW)) begin
                  cnt_in = 7'(DIVW + 1);
               end else if (cnt_ff == 7'(DIVW + 1)) begin
                  // Saturate and apply sign
                  dnum_in = dnum_ff;
                  drem_in = drem_ff;
                  dquo_in = dquo_ff;
                  if (raw_ff[rsel][32]) begin
                     coef_in = (dquo_ff > DIVW'(33'h0_8000_0000)) ? 32'sh8000_0000
                               : 32'(-dquo_ff);
                  end else begin
                     coef_in = (dquo_ff > DIVW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                               : 32'(dquo_ff);
                  end
                  state_in = ST_CWR;
               end else begin
                  cnt_in = cnt_ff + 7'd1;
               end
            end
         end
         ST_CWR: begin
            pl_we  = 1'b1;
            cnt_in = '0;
            if (step_ff == 3'd3) begin
               state_in = ST_CNEXT;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = ST_CDIV;
            end
         end
         ST_CNEXT: begin
            step_in = '0;
            cnt_in  = '0;
            if (plane_ff == 3'(fpsc_pkg::NUM_PLANES - 1)) begin
               state_in = ST_RESP;
            end else begin
               plane_in = plane_ff + 3'd1;
               state_in = ST_CRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clip_ff      <= 1'b1;
         planes_ok_ff <= 1'b0;
         vis_ff       <= 1'b1;
         plane_ff     <= '0;
         step_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         vis_ff   <= vis_in;
         plane_ff <= plane_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         if (csr_valid && csr_ready) begin
            clip_ff <= csr_clip_enable;
         end
         if (state_ff == ST_CNEXT && plane_ff == 3'(fpsc_pkg::NUM_PLANES - 1)) begin
            planes_ok_ff <= 1'b1;
         end
      end
   end

   // Payload and datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_start) begin
         eidx_ff <= req_elem_index;
         eval_ff <= req_elem_value;
         cx_ff   <= req_center_x;
         cy_ff   <= req_center_y;
         cz_ff   <= req_center_z;
         rad_ff  <= req_sphere_radius;
      end
      acc_ff  <= acc_in;
      raw_ff  <= raw_in;
      colw_ff <= colw_in;
      ssq_ff  <= ssq_in;
      sqn_ff  <= sqn_in;
      sqr_ff  <= sqr_in;
      dnum_ff <= dnum_in;
      dquo_ff <= dquo_in;
      drem_ff <= drem_in;
      coef_ff <= coef_in;
   end

endmodule

@@ bench/frustum_plane_sphere_cull_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_plane_sphere_cull_checker: visibility predictor and response check
// Watches command, response and csr beats, keeps its own matrix, plane store
// and clip enable, predicts the visible bit of every command and compares it
// with each response in order.
// ----------------------------------------------------------------------------
module frustum_plane_sphere_cull_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   input  logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_elem_index,
   input  logic signed [31:0] req_elem_value,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic [30:0] req_sphere_radius,
   input  logic        rsp_valid,
   input  logic        rsp_visible,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_clip_enable,
   output int          fail_count,
   output int          pending
);

   localparam int FRAC = fpsc_pkg::FRAC_BITS_DEF;
   localparam logic [1:0] COL_OF [6] = '{2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1};
   localparam logic       ADD_OF [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

   logic signed [31:0] mat_q [16];
   logic signed [31:0] plane_q [24];
   logic               clip_en;
   logic               visible_q [$];

   initial fail_count = 0;
   initial pending = 0;

   task automatic report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res = 0;
      longint unsigned bitv = 64'h4000_0000_0000_0000;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   // Derive six planes and scale each to a unit normal
   task automatic build_planes();
      longint s [4];
      longint unsigned sum, len, q;
      logic big;
      for (int p = 0; p < 6; p++) begin
         big = 1'b0;
         sum = 0;
         for (int r = 0; r < 4; r++) begin
            s[r] = ADD_OF[p] ? longint'(mat_q[r*4+3]) + longint'(mat_q[r*4+COL_OF[p]])
                             : longint'(mat_q[r*4+3]) - longint'(mat_q[r*4+COL_OF[p]]);
         end
         for (int r = 0; r < 3; r++)
            if (magnitude(s[r]) >= 64'h8000_0000) big = 1'b1;
         if (big)
            for (int r = 0; r < 4; r++) s[r] = s[r] >>> 1;
         for (int r = 0; r < 3; r++) sum += magnitude(s[r]) * magnitude(s[r]);
         len = int_sqrt(sum);
         for (int r = 0; r < 4; r++) begin
            if (len == 0) begin
               plane_q[p*4+r] = '0;
            end else begin
               q = (magnitude(s[r]) << FRAC) / len;
               if (s[r] < 0)
                  plane_q[p*4+r] = (q > 64'h8000_0000) ? 32'sh8000_0000
                                                       : 32'(-longint'(q));
               else
                  plane_q[p*4+r] = (q > 64'h7fff_ffff) ? 32'sh7fff_ffff : q[31:0];
            end
         end
      end
   endtask

   // Exact plane distance sum; culled when any plane goes negative
   function automatic logic sphere_visible(input longint cx, cy, cz, rad);
      logic signed [66:0] plane_sum;
      if (!clip_en) return 1'b1;
      for (int p = 0; p < 6; p++) begin
         plane_sum = 0;
         plane_sum += longint'(plane_q[p*4]) * cx;
         plane_sum += longint'(plane_q[p*4+1]) * cy;
         plane_sum += longint'(plane_q[p*4+2]) * cz;
         plane_sum += longint'(plane_q[p*4+3]) <<< FRAC;
         plane_sum += rad <<< FRAC;
         if (plane_sum < 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Track state, predict on each command beat, check each response beat
   always @(posedge clock) begin
      logic want;
      if (reset) begin
         foreach (mat_q[i]) mat_q[i] = '0;
         foreach (plane_q[i]) plane_q[i] = '0;
         clip_en = 1'b1;
         visible_q.delete();
         pending = 0;
      end else begin
         if (rsp_valid) begin
            if (visible_q.size() == 0) begin
               report("response beat with nothing outstanding");
            end else begin
               want = visible_q.pop_front();
               if (rsp_visible !== want)
                  report($sformatf("visible got %b want %b", rsp_visible, want));
            end
         end
         if (csr_valid && csr_ready) clip_en = csr_clip_enable;
         if (req_start && !busy) begin
            want = 1'b1;
            case (fpsc_pkg::cmd_type'(req_cmd))
               fpsc_pkg::CMD_LOAD:    mat_q[req_elem_index] = req_elem_value;
               fpsc_pkg::CMD_COMPUTE: build_planes();
               fpsc_pkg::CMD_TEST:
                  want = sphere_visible(req_center_x, req_center_y,
                                        req_center_z, {33'd0, req_sphere_radius});
               default:     ;
            endcase
            visible_q.push_back(want);
         end
         pending = visible_q.size();
      end
   end

endmodule

@@ bench/frustum_plane_sphere_cull_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_plane_sphere_cull_tb: stimulus and verdict for the sphere cull block
// Loads matrices, computes planes and tests spheres, first directed corner
// cases then random traffic under several idle patterns and clip settings.
// ----------------------------------------------------------------------------
module frustum_plane_sphere_cull_tb;

   localparam int STALL_LIMIT = 20000;
   localparam logic signed [31:0] ONE = 32'sd65536;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = fpsc_pkg::CMD_NONE;
   logic [3:0]  req_elem_index = '0;
   logic signed [31:0] req_elem_value = '0;
   logic signed [31:0] req_center_x = '0;
   logic signed [31:0] req_center_y = '0;
   logic signed [31:0] req_center_z = '0;
   logic [30:0] req_sphere_radius = '0;
   logic        rsp_valid;
   logic        rsp_visible;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_clip_enable = 1'b1;
   int          fail_count;
   int          pending;
   int          idle_pct = 0;
   int          stall_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   frustum_plane_sphere_cull u_top (.*);

   frustum_plane_sphere_cull_checker u_checker (.*);

   // Stop the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Present one command beat, with an optional leading gap
   task automatic issue(input fpsc_pkg::cmd_type c, input logic [3:0] idx,
                        input logic signed [31:0] ev, cx, cy, cz,
                        input logic [30:0] rad);
      if ($urandom_range(99) < idle_pct) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_start         <= 1'b1;
      req_cmd           <= c;
      req_elem_index    <= idx;
      req_elem_value    <= ev;
      req_center_x      <= cx;
      req_center_y      <= cy;
      req_center_z      <= cz;
      req_sphere_radius <= rad;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic load(input logic [3:0] idx, input logic signed [31:0] v);
      issue(fpsc_pkg::CMD_LOAD, idx, v, $urandom, $urandom, $urandom, 31'($urandom));
   endtask

   task automatic test(input logic signed [31:0] cx, cy, cz, input logic [30:0] rad);
      issue(fpsc_pkg::CMD_TEST, 4'($urandom), $urandom, cx, cy, cz, rad);
   endtask

   // Hold off until every outstanding response has come back
   task automatic drain();
      req_start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_clip(input logic en);
      drain();
      csr_valid       <= 1'b1;
      csr_clip_enable <= en;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] near_val(input int span_log2);
      return $signed($urandom_range(0, (1 << (span_log2 + 1)) - 1)) - (1 << span_log2);
   endfunction

   // Random traffic: mostly tests against a sane frustum, some matrix churn
   task automatic random_items(input int pct, input int count);
      int r;
      idle_pct = pct;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 2) begin
            // fresh well-formed frame: scaled identity with random perturbation
            for (int i = 0; i < 16; i++)
               load(4'(i), ((i % 5) == 0 ? ONE : 32'sd0) + near_val(15));
            issue(fpsc_pkg::CMD_COMPUTE, 4'($urandom), $urandom, $urandom, $urandom,
                  $urandom, 31'($urandom));
         end else if (r < 4) begin
            issue(fpsc_pkg::CMD_COMPUTE, 4'($urandom), $urandom, $urandom, $urandom,
                  $urandom, 31'($urandom));
         end else if (r < 14) begin
            load(4'($urandom), ($urandom_range(3) == 0) ? $urandom : near_val(18));
         end else if (r < 18) begin
            issue(fpsc_pkg::CMD_NONE, 4'($urandom), $urandom, $urandom, $urandom,
                  $urandom, 31'($urandom));
         end else if (r < 30) begin
            test($urandom, $urandom, $urandom, 31'($urandom));
         end else begin
            test(near_val(18), near_val(18), near_val(18),
                 31'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 17)));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Planes read as zero before the first compute: all spheres visible
      test(32'sh8000_0000, 32'sh7fff_ffff, 0, 31'd0);
      // Identity matrix, then inside, outside and extreme spheres
      for (int i = 0; i < 16; i++) load(4'(i), (i % 5) == 0 ? ONE : 32'sd0);
      issue(fpsc_pkg::CMD_COMPUTE, 4'd0, 0, 0, 0, 0, 31'd0);
      test(0, 0, 0, 31'd0);
      test(2 * ONE, 0, 0, 31'd0);
      test(2 * ONE, 0, 0, 31'h7fff_ffff);
      test(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff);
      // Zero normal on the near and far planes
      load(4'd10, 32'sd0);
      issue(fpsc_pkg::CMD_COMPUTE, 4'd0, 0, 0, 0, 0, 31'd0);
      test(0, 0, 3 * ONE, 31'd0);
      // Extreme elements force the halving path
      load(4'd0, 32'sh7fff_ffff);
      load(4'd3, 32'sh7fff_ffff);
      load(4'd4, 32'sh8000_0000);
      issue(fpsc_pkg::CMD_COMPUTE, 4'd0, 0, 0, 0, 0, 31'd0);
      test(-ONE, ONE, 0, 31'd0);
      issue(fpsc_pkg::CMD_NONE, 4'hf, 32'shffff_ffff, -1, -1, -1, 31'h7fff_ffff);
      write_clip(1'b0);
      test(32'sh7fff_ffff, 0, 0, 31'd0);
      write_clip(1'b1);

      random_items(14, 150);
      write_clip(1'b0);
      random_items(88, 60);
      write_clip(1'b1);
      random_items(88, 110);
      drain();
      random_items(0, 150);
      drain();

      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
